[sv/lpep_pkg.sv]
// ----------------------------------------------------------------------------
// lpep_pkg
// shared types and constants of the led panel ethernet packetizer
// ----------------------------------------------------------------------------
package lpep_pkg;

    localparam int SIZE_W  = 13;
    localparam int ROW_W   = 12;
    localparam int START_W = 12;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_ENABLE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_IDENTIFIER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_BRIGHTNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_BRIGHTNESS  = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in;

    typedef struct packed {
        logic [63:0] packet_word;
        logic [3:0]  valid_bytes;
        logic        packet_end;
        logic        frame_end;
        logic        run_last;
    } t_out;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_PIX,
        PH_BRT,
        PH_DSP
    } t_phase;

    typedef struct packed {
        logic               hdr;
        logic               chunk_end;
        logic               frame_last;
        logic [ROW_W-1:0]   row;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        t_in                pixel;
    } t_ctx;

    typedef struct packed {
        logic        tag_enable;
        logic [11:0] tag_identifier;
        logic [7:0]  linear_brightness;
        logic [7:0]  curve_brightness;
    } t_fmt_cfg;

    typedef struct packed {
        logic   phase_last;
        logic   item_last;
        t_phase next_phase;
    } t_seq;

endpackage

[sv/lpep_word_gen.sv]
// ----------------------------------------------------------------------------
// lpep_word_gen
// forms one 8-byte output beat of the current pixel's sequence of packets
// ----------------------------------------------------------------------------
module lpep_word_gen
    import lpep_pkg::*;
(
    input  t_ctx             i_ctx,
    input  t_fmt_cfg         i_cfg,
    input  t_phase           i_phase,
    input  logic [IDX_W-1:0] i_idx,
    output t_out             o_word,
    output t_seq             o_seq
);

    localparam logic [95:0] MAC_PAIR  = 96'h112233445566_222233445566;
    localparam logic [15:0] VLAN_TPID = 16'h8100;
    localparam logic [3:0]  VLAN_PRIO = 4'hE;
    localparam logic [15:0] CHUNK_TYPE = 16'h5500;
    localparam logic [15:0] BRT_TYPE   = 16'h0107;
    localparam logic [15:0] DSP_TYPE   = 16'h0A00;
    localparam logic [7:0]  CHUNK_B0   = 8'h08;
    localparam logic [7:0]  CHUNK_B1   = 8'h88;
    localparam logic [7:0]  BRT_MODE   = 8'h05;
    localparam logic [7:0]  DSP_FULL   = 8'hFF;

    logic [31:0]          vlan_tag;
    logic [15:0]          chunk_type;
    logic [15:0]          dsp_type;
    logic [55:0]          chunk_body;
    logic [783:0]         brt_body;
    logic [503:0]         dsp_body;
    logic [0:3][63:0]     w_hdr;
    logic [0:14][63:0]    w_brt;
    logic [0:10][63:0]    w_dsp;
    logic [63:0]          data;
    logic [3:0]           last_bytes;
    logic                 phase_last;
    logic                 item_last;
    t_phase               next_phase;

    always_comb begin
        vlan_tag   = {VLAN_TPID, VLAN_PRIO, i_cfg.tag_identifier};
        chunk_type = CHUNK_TYPE + {8'h00, 4'h0, i_ctx.row[11:8]};
        dsp_type   = DSP_TYPE + {8'h00, i_cfg.curve_brightness};
        chunk_body = {i_ctx.row[7:0], 4'h0, i_ctx.start, 7'h00, i_ctx.count,
                      CHUNK_B0, CHUNK_B1};
        brt_body   = {168'h0, i_cfg.linear_brightness, BRT_MODE, 8'h00,
                      i_cfg.linear_brightness, i_cfg.linear_brightness,
                      i_cfg.linear_brightness, 568'h0};
        dsp_body   = {i_cfg.curve_brightness, i_cfg.curve_brightness, DSP_FULL,
                      480'h0};

        if (i_cfg.tag_enable) begin
            w_hdr = {MAC_PAIR, vlan_tag, chunk_type, chunk_body, 56'h0};
            w_brt = {MAC_PAIR, vlan_tag, BRT_TYPE, brt_body, 32'h0};
            w_dsp = {MAC_PAIR, vlan_tag, dsp_type, dsp_body, 56'h0};
        end else begin
            w_hdr = {MAC_PAIR, chunk_type, chunk_body, 88'h0};
            w_brt = {MAC_PAIR, BRT_TYPE, brt_body, 64'h0};
            w_dsp = {MAC_PAIR, dsp_type, dsp_body, 88'h0};
        end
    end

    always_comb begin
        unique case (i_phase)
            PH_HDR: begin
                data       = w_hdr[i_idx[1:0]];
                phase_last = (i_idx == (i_cfg.tag_enable ? 4'd3 : 4'd2));
                last_bytes = i_cfg.tag_enable ? 4'd1 : 4'd5;
                next_phase = PH_PIX;
            end
            PH_PIX: begin
                data       = {i_ctx.pixel, 40'h0};
                phase_last = 1'b1;
                last_bytes = 4'd3;
                next_phase = PH_BRT;
            end
            PH_BRT: begin
                data       = w_brt[i_idx];
                phase_last = (i_idx == (i_cfg.tag_enable ? 4'd14 : 4'd13));
                last_bytes = i_cfg.tag_enable ? 4'd4 : 4'd8;
                next_phase = PH_DSP;
            end
            PH_DSP: begin
                data       = w_dsp[i_idx];
                phase_last = (i_idx == (i_cfg.tag_enable ? 4'd10 : 4'd9));
                last_bytes = i_cfg.tag_enable ? 4'd1 : 4'd5;
                next_phase = PH_DSP;
            end
            default: begin
                data       = '0;
                phase_last = 1'b1;
                last_bytes = 4'd8;
                next_phase = PH_PIX;
            end
        endcase

        item_last = phase_last &&
                    ((i_phase == PH_DSP) || ((i_phase == PH_PIX) && !i_ctx.frame_last));

        o_word.packet_word = data;
        o_word.valid_bytes = phase_last ? last_bytes : 4'd8;
        o_word.packet_end  = (i_phase == PH_PIX) ? i_ctx.chunk_end
                                                 : (phase_last && (i_phase != PH_HDR));
        o_word.frame_end   = phase_last && (i_phase == PH_DSP);
        o_word.run_last    = item_last;

        o_seq.phase_last = phase_last;
        o_seq.item_last  = item_last;
        o_seq.next_phase = next_phase;
    end

endmodule

[sv/led_panel_ethernet_packetizer.sv]
// ----------------------------------------------------------------------------
// led_panel_ethernet_packetizer
// cuts a row-major rgb pixel stream into raw ethernet frames for an led panel
//
//   channel  direction  handshake                payload
//   in       sink       i_in_valid / o_in_ready   t_in  (red, green, blue)
//   out      source     o_out_valid / i_out_ready t_out (word, bytes, flags)
//   cfg      sink       i_cfg_valid / o_cfg_ready index + data
//
// one output beat per cycle; a pixel inside a chunk is a single beat, the first
// pixel of a chunk adds 3 header beats (4 tagged), the last pixel of a frame
// adds 24 beats (26 tagged) for the brightness and display packets.
// the next pixel is taken in the cycle its predecessor's last beat is loaded
// into the output register; a stalled output holds the sequencer.
// reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module led_panel_ethernet_packetizer
    import lpep_pkg::*;
#(
    parameter int PIXELS_PER_PACKET = 497,
    parameter int ROW_CAPACITY      = 512,
    parameter int MAX_COLUMNS       = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW  = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RMW = (PIXELS_PER_PACKET > 1) ? $clog2(PIXELS_PER_PACKET) : 1;
    localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(ROW_CAPACITY);
    localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLUMNS);
    localparam logic [SIZE_W-1:0] PPP      = SIZE_W'(PIXELS_PER_PACKET);

    logic [9:0]  r_row_count;
    logic [10:0] r_column_count;
    logic        r_tag_enable;
    logic [11:0] r_tag_identifier;
    logic [7:0]  r_linear_brightness;
    logic [7:0]  r_curve_brightness;

    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic [RMW-1:0] r_rem;
    logic [RW-1:0]  n_row;
    logic [CW-1:0]  n_col;
    logic [RMW-1:0] n_rem;

    logic             r_busy;
    t_ctx             r_ctx;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out             r_out_data;

    t_ctx     n_ctx;
    t_fmt_cfg fmt_cfg;
    t_out     word;
    t_seq     seq;
    logic     load;
    logic     accept;

    logic [SIZE_W-1:0] rows_c, cols_c, row_w, col_w, rem_w;
    logic [SIZE_W-1:0] col1, row1, rem1, start, cnt_raw, count;
    logic              row_end, frame_last;

    // frame geometry and chunk context of the incoming pixel
    always_comb begin
        rows_c = {3'b000, r_row_count};
        if (rows_c == '0) begin
            rows_c = SIZE_W'(1);
        end else if (rows_c > ROWS_MAX) begin
            rows_c = ROWS_MAX;
        end
        cols_c = {2'b00, r_column_count};
        if (cols_c == '0) begin
            cols_c = SIZE_W'(1);
        end else if (cols_c > COLS_MAX) begin
            cols_c = COLS_MAX;
        end

        row_w = SIZE_W'(r_row);
        col_w = SIZE_W'(r_col);
        rem_w = SIZE_W'(r_rem);
        if (col_w >= cols_c) begin
            col_w = '0;
            rem_w = '0;
        end
        if (row_w >= rows_c) begin
            row_w = '0;
        end

        start   = col_w - rem_w;
        cnt_raw = cols_c - start;
        count   = (cnt_raw > PPP) ? PPP : cnt_raw;

        col1       = col_w + SIZE_W'(1);
        row1       = row_w + SIZE_W'(1);
        rem1       = rem_w + SIZE_W'(1);
        row_end    = (col1 >= cols_c);
        frame_last = row_end && (row1 >= rows_c);

        n_col = row_end ? '0 : CW'(col1);
        n_rem = (row_end || (rem1 == PPP)) ? '0 : RMW'(rem1);
        n_row = row_end ? (frame_last ? '0 : RW'(row1)) : RW'(row_w);

        n_ctx.hdr        = (rem_w == '0);
        n_ctx.chunk_end  = (rem1 >= count);
        n_ctx.frame_last = frame_last;
        n_ctx.row        = ROW_W'(row_w);
        n_ctx.start      = START_W'(start);
        n_ctx.count      = COUNT_W'(count);
        n_ctx.pixel      = i_in_data;
    end

    assign fmt_cfg.tag_enable        = r_tag_enable;
    assign fmt_cfg.tag_identifier    = r_tag_identifier;
    assign fmt_cfg.linear_brightness = r_linear_brightness;
    assign fmt_cfg.curve_brightness  = r_curve_brightness;

    lpep_word_gen u_word_gen (
        .i_ctx   (r_ctx),
        .i_cfg   (fmt_cfg),
        .i_phase (r_phase),
        .i_idx   (r_idx),
        .o_word  (word),
        .o_seq   (seq)
    );

    assign load        = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_busy || (load && seq.item_last);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count         <= 10'd64;
            r_column_count      <= 11'd64;
            r_tag_enable        <= 1'b0;
            r_tag_identifier    <= '0;
            r_linear_brightness <= 8'hFF;
            r_curve_brightness  <= 8'hFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:         r_row_count         <= i_cfg_data[9:0];
                CFG_COLUMN_COUNT:      r_column_count      <= i_cfg_data[10:0];
                CFG_TAG_ENABLE:        r_tag_enable        <= i_cfg_data[0];
                CFG_TAG_IDENTIFIER:    r_tag_identifier    <= i_cfg_data[11:0];
                CFG_LINEAR_BRIGHTNESS: r_linear_brightness <= i_cfg_data[7:0];
                CFG_CURVE_BRIGHTNESS:  r_curve_brightness  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_rem  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (accept) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_rem   <= n_rem;
                r_busy  <= 1'b1;
                r_ctx   <= n_ctx;
                r_phase <= n_ctx.hdr ? PH_HDR : PH_PIX;
                r_idx   <= '0;
            end else if (load) begin
                if (seq.item_last) begin
                    r_busy <= 1'b0;
                end else if (seq.phase_last) begin
                    r_phase <= seq.next_phase;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= word;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_busy) |-> (load && seq.item_last))
        else $error("pixel taken while earlier beats pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("sequencer idle after pixel taken");

    a_frame_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.frame_end) |->
            (r_out_data.packet_end && r_out_data.run_last))
        else $error("frame end beat without packet end or run end");

endmodule
